@@ design/sqp_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package sqp_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ design/sorted_priority_queue.sv @@
// Top level of the min-first sorted priority queue built from a chain of cells.
//
// Usage:
//   Drive operation_i and value_i with start_i high; the item is accepted at
//   any edge where start_i is high and busy_o is low. busy_o stays low, so an
//   item can be issued in every cycle.
//   Enqueue inserts value_i into sorted position: every cell whose value is
//   larger takes its lower neighbor, and the first such cell (or the first
//   free one) takes the new value. Dequeue shifts every cell down by one and
//   returns the old head.
//   Each item gives one result in the cycle right after it is accepted,
//   marked by valid_o for exactly one cycle: status, removed value, the new
//   head and the occupancy. Throughput is one item per cycle; the compare in
//   every cell plus the head select set the path.
//   Dequeue on an empty queue reports an empty error, enqueue on a full
//   queue reports a full error and drops the value; state is unchanged.
//   Reset clears the occupancy and the result strobe; cell contents are not
//   cleared and are read only below the occupancy.
//   The receiver cannot stall: a result not taken in its cycle is gone.
module sorted_priority_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic signed [sqp_pkg::DATA_W-1:0] value_i,
  output logic                              valid_o,
  output logic [sqp_pkg::STAT_W-1:0]        status_o,
  output logic signed [sqp_pkg::DATA_W-1:0] removed_value_o,
  output logic signed [sqp_pkg::DATA_W-1:0] head_value_o,
  output logic [sqp_pkg::OCC_W-1:0]         occupancy_o
);
  import sqp_pkg::*;

  logic                     accept;
  logic                     none_held;
  logic                     is_full;
  status_e                  status_d;
  cell_ctrl_t               ctrl;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;

  logic                     valid_q;
  status_e                  status_q;
  logic signed [DATA_W-1:0] removed_q;
  logic signed [DATA_W-1:0] removed_d;
  logic signed [DATA_W-1:0] head_q;
  logic signed [DATA_W-1:0] head_d;
  logic [OCC_W-1:0]         occ_q;

  logic                     occ     [CAPACITY];
  logic                     gt      [CAPACITY];
  logic signed [DATA_W-1:0] cell_d  [CAPACITY];
  logic signed [DATA_W-1:0] cell_q  [CAPACITY];

  // One item per cycle: never hold off the issuer.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign none_held = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(CAPACITY));

  // Decode the operation and pick the status.
  always_comb begin
    ctrl.enq   = 1'b0;
    ctrl.deq   = 1'b0;
    ctrl.value = value_i;
    status_d   = ST_OK;
    count_d    = count_q;
    removed_d  = '0;
    if (accept) begin
      unique case (op_e'(operation_i))
        OP_ENQ: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.enq = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_DEQ: begin
          if (none_held) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.deq  = 1'b1;
            count_d   = count_q - CNT_W'(1);
            removed_d = cell_q[0];
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // Build the chain: each cell sees its lower and upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     lower_gt;
    logic signed [DATA_W-1:0] lower_value;
    logic signed [DATA_W-1:0] upper_value;

    assign occ[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign lower_gt    = 1'b0;
      assign lower_value = '0;
    end else begin : g_mid
      assign lower_gt    = gt[i-1];
      assign lower_value = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_value = cell_q[i];
    end else begin : g_inner
      assign upper_value = cell_q[i+1];
    end

    sqp_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ[i]),
      .lower_gt_i    (lower_gt),
      .lower_value_i (lower_value),
      .upper_value_i (upper_value),
      .gt_o          (gt[i]),
      .value_d_o     (cell_d[i]),
      .value_q_o     (cell_q[i])
    );
  end

  // Head after the operation comes from the next value of the first cell.
  assign head_d = (count_d != '0) ? cell_d[0] : '0;

  // Hold the occupancy and the strobe under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // Result payload: capture on accept, hold until the next accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      head_q    <= head_d;
      occ_q     <= OCC_W'(count_d);
    end
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign head_value_o    = head_q;
  assign occupancy_o     = occ_q;

endmodule

@@ design/sqp_cell.sv @@
// One storage cell of the sorted queue chain.
module sqp_cell (
  input  logic                             clk_i,
  input  sqp_pkg::cell_ctrl_t              ctrl_i,
  input  logic                             occ_i,
  input  logic                             lower_gt_i,
  input  logic signed [sqp_pkg::DATA_W-1:0] lower_value_i,
  input  logic signed [sqp_pkg::DATA_W-1:0] upper_value_i,
  output logic                             gt_o,
  output logic signed [sqp_pkg::DATA_W-1:0] value_d_o,
  output logic signed [sqp_pkg::DATA_W-1:0] value_q_o
);
  import sqp_pkg::*;

  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] value_d;

  // Held value is larger than the new one: it moves up on insert.
  assign gt_o = occ_i && (value_q > ctrl_i.value);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.deq) begin
      value_d = upper_value_i;
    end else if (ctrl_i.enq) begin
      if (lower_gt_i) begin
        value_d = lower_value_i;
      end else if (gt_o || !occ_i) begin
        value_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_d_o = value_d;
  assign value_q_o = value_q;

endmodule

@@ tb/sorted_priority_queue_test.sv @@
// Self-checking testbench for the sorted min-first priority queue.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import sqp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1350;
  localparam int unsigned QUIET_TAIL    = 150;     // final items issued back to back
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned ERR_PRINT_MAX = 40;

  // One result item as the block reports it.
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] head;
    logic [OCC_W-1:0]         occ;
  } queue_result_t;

  // One row of the directed stimulus; typed rows carry their own result.
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    queue_result_t            res;
  } directed_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic                     operation_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     valid_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] removed_value_o;
  logic signed [DATA_W-1:0] head_value_o;
  logic [OCC_W-1:0]         occupancy_o;

  // Travel with start_i so the monitor knows which expectation to queue.
  logic                     row_typed = 1'b0;
  queue_result_t            row_result = '0;

  // Shadow copy of the queue contents.
  logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
  int unsigned              shadow_count = 0;

  queue_result_t            awaited_results [$];
  directed_row_t            directed_rows [$];

  int unsigned              cycle_count = 0;
  int unsigned              mismatch_count = 0;
  int unsigned              items_accepted = 0;
  int unsigned              empty_hits = 0;
  int unsigned              full_hits = 0;
  int unsigned              peak_occupancy = 0;

  sorted_priority_queue DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .head_value_o    (head_value_o),
    .occupancy_o     (occupancy_o)
  );

  always #4 clk_i = ~clk_i;

  // Apply one item to the shadow queue and return the result it should give.
  function automatic queue_result_t queue_step(op_e op, logic signed [DATA_W-1:0] val);
    queue_result_t r;
    int            i;
    r.status  = ST_OK;
    r.removed = '0;
    if (op == OP_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // shift larger cells up; equal values stay ahead of the new one
        i = shadow_count;
        while (i > 0 && shadow_cells[i-1] > val) begin
          shadow_cells[i] = shadow_cells[i-1];
          i--;
        end
        shadow_cells[i] = val;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = shadow_cells[0];
        for (i = 1; i < shadow_count; i++) shadow_cells[i-1] = shadow_cells[i];
        shadow_count--;
      end
    end
    r.head = (shadow_count > 0) ? shadow_cells[0] : '0;
    r.occ  = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic void add_row(op_e op, logic signed [DATA_W-1:0] val, logic typed,
                                  status_e st, logic signed [DATA_W-1:0] rem,
                                  logic signed [DATA_W-1:0] head, logic [OCC_W-1:0] occ);
    directed_row_t row;
    row.op          = op;
    row.value       = val;
    row.typed       = typed;
    row.res.status  = st;
    row.res.removed = rem;
    row.res.head    = head;
    row.res.occ     = occ;
    directed_rows.push_back(row);
  endfunction

  // Value classes: wide random, a narrow band full of duplicates, the extremes.
  function automatic logic signed [DATA_W-1:0] pick_value(int mode);
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    if (mode == 1 && $urandom_range(0, 7) != 0) begin
      v = int'($urandom_range(0, 15)) - 8;
    end else if (mode == 2 && $urandom_range(0, 7) != 0) begin
      case ($urandom_range(0, 6))
        0: v = 32'sh8000_0000;
        1: v = 32'sh8000_0001;
        2: v = -32'sd1;
        3: v = 32'sd0;
        4: v = 32'sd1;
        5: v = 32'sh7FFF_FFFE;
        default: v = 32'sh7FFF_FFFF;
      endcase
    end
    return v;
  endfunction

  function automatic int idle_gap();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 11)) : 0;
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(op_e op, logic signed [DATA_W-1:0] val, logic typed,
                           queue_result_t res, int idle);
    if (idle > 0) begin
      start_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    row_typed   <= typed;
    row_result  <= res;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Check results as they come, then queue the expectation of any accepted item.
  always @(posedge clk_i) begin
    queue_result_t got;
    queue_result_t want;
    queue_result_t predicted;
    if (rst_ni) begin
      if (valid_o) begin
        got.status  = status_e'(status_o);
        got.removed = removed_value_o;
        got.head    = head_value_o;
        got.occ     = occupancy_o;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ERR_PRINT_MAX)
            $display("%0t: unexpected result status=%0d removed=%0d head=%0d occ=%0d",
                     $time, got.status, got.removed, got.head, got.occ);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.removed !== want.removed ||
              got.head !== want.head || got.occ !== want.occ) begin
            mismatch_count++;
            if (mismatch_count <= ERR_PRINT_MAX) begin
              $display("%0t: mismatch expected status=%0d removed=%0d head=%0d occ=%0d",
                       $time, want.status, want.removed, want.head, want.occ);
              $display("%0t:          actual   status=%0d removed=%0d head=%0d occ=%0d",
                       $time, got.status, got.removed, got.head, got.occ);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        predicted = queue_step(op_e'(operation_i), value_i);
        awaited_results.push_back(row_typed ? row_result : predicted);
        items_accepted++;
        if (predicted.status == ST_EMPTY) empty_hits++;
        if (predicted.status == ST_FULL) full_hits++;
        if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
      end
    end
  end

  // Watchdog: stop a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int          phase_len;
    int          enq_pct;
    int          vmode;
    bit          idle_on;
    op_e         op;
    int          k;

    // Directed rows: empty queue, both extremes, ordering, then fill past capacity.
    add_row(OP_DEQ, 32'sd0,           1'b1, ST_EMPTY, 32'sd0, 32'sd0, 5'd0);
    add_row(OP_ENQ, 32'sh7FFF_FFFF,   1'b1, ST_OK, 32'sd0, 32'sh7FFF_FFFF, 5'd1);
    add_row(OP_ENQ, 32'sh8000_0000,   1'b1, ST_OK, 32'sd0, 32'sh8000_0000, 5'd2);
    add_row(OP_DEQ, -32'sd1,          1'b1, ST_OK, 32'sh8000_0000, 32'sh7FFF_FFFF, 5'd1);
    add_row(OP_DEQ, 32'sh7FFF_FFFF,   1'b1, ST_OK, 32'sh7FFF_FFFF, 32'sd0, 5'd0);
    add_row(OP_DEQ, 32'sh8000_0000,   1'b1, ST_EMPTY, 32'sd0, 32'sd0, 5'd0);
    add_row(OP_ENQ, 32'sd5,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, -32'sd3,          1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd5,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd0,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, -32'sd1,          1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sh7FFF_FFFF,   1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sh8000_0000,   1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd1,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sh8000_0001,   1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd100,         1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, -32'sd100,        1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd5,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd0,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd7,           1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, -32'sd7,          1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sd2,           1'b0, ST_OK, '0, '0, '0);
    // queue is full now: the next two values are dropped
    add_row(OP_ENQ, -32'sd2,          1'b0, ST_OK, '0, '0, '0);
    add_row(OP_ENQ, 32'sh8000_0000,   1'b0, ST_OK, '0, '0, '0);
    add_row(OP_DEQ, 32'sh5A5A_A5A5,   1'b0, ST_OK, '0, '0, '0);

    // Hold reset, then release it on a clock edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].res, 0);

    // Random part in phases: each phase leans toward filling or draining,
    // picks a value class and turns idling on or off.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0: enq_pct = 90;
        1: enq_pct = 70;
        2: enq_pct = 50;
        3: enq_pct = 30;
        default: enq_pct = 10;
      endcase
      vmode   = $urandom_range(0, 2);
      idle_on = ($urandom_range(0, 2) != 0);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_item(op, pick_value(vmode), 1'b0, '0,
                  (idle_on && sent < RANDOM_ITEMS - QUIET_TAIL) ? idle_gap() : 0);
        sent++;
      end
    end
    start_i <= 1'b0;

    // Drain: wait for every outstanding result, then a few more cycles.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end

    $display("Run covered %0d items: %0d dequeues on empty, %0d enqueues on full,",
             items_accepted, empty_hits, full_hits);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occupancy, CAPACITY,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
